FILE: rtl/spmd_pkg.sv
package spmd_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PULSE_RATIO   = 2'd0,
		CFG_MIN_CARRIER   = 2'd1,
		CFG_MAX_MOD_INDEX = 2'd2
	} cfg_index_t;

	localparam logic [7:0]  PULSE_RATIO_RST   = 8'd9;
	localparam logic [19:0] MIN_CARRIER_RST   = 20'd16000;
	localparam logic [14:0] MAX_MOD_INDEX_RST = 15'd16384;

	// 1/(2*pi) in Q32 and sqrt(3)/2 in Q16.
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;

	localparam logic [15:0] DUTY_HALF = 16'd32768;
	localparam logic [15:0] DUTY_MAX  = 16'd65535;
	localparam logic [23:0] FREQ_MAX  = 24'hFFFFFF;
	localparam logic [14:0] BUS_MIN   = 15'd32;

	// Divider geometry: numerator 2N+D below 2^51, divisor 2D below 2^33.
	localparam int QUO_W     = 17;
	localparam int DIV_STEPS = QUO_W;
	localparam int REM_W     = 51;
	localparam int DEN_W     = 33;
	localparam logic [QUO_W-1:0] QUO_CLAMP = 17'd65536;

	// Pipeline depths.
	localparam int FRONT_LAT = 4;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int FREQ_LAT  = 3;
	localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;
	localparam int FREQ_DLY  = PIPE_LAT - FREQ_LAT;

	typedef struct packed {
		logic [REM_W-1:0] x;
		logic [DEN_W-1:0] y;
		logic             ovf;
		logic             neg;
		logic             low_bus;
	} spmd_div_in_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] y;
		logic [QUO_W-1:0] q;
		logic             ovf;
		logic             neg;
		logic             low_bus;
	} spmd_div_step_t;

endpackage

FILE: rtl/spmd_freq.sv
module spmd_freq import spmd_pkg::*; (
	input  logic               clk,
	input  logic signed [19:0] speed,
	input  logic [7:0]         pulse_ratio,
	input  logic [19:0]        min_carrier,
	output logic [23:0]        freq
);

	logic [19:0] speed_mag;
	logic [27:0] prod_s1;
	logic [42:0] lo_s2;
	logic [42:0] hi_s2;
	logic [58:0] sum;
	logic [26:0] target;
	logic [26:0] floor_val;

	// The most negative speed wraps to 2^19, which is its true magnitude.
	assign speed_mag = speed[19] ? 20'(-speed) : 20'(speed);

	always_comb begin
		sum       = (59'(hi_s2) << 15) + 59'(lo_s2) + (59'd1 << 31);
		target    = sum[58:32];
		floor_val = (target < 27'(min_carrier)) ? 27'(min_carrier) : target;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 28'(speed_mag) * 28'(pulse_ratio);
		lo_s2   <= 43'(prod_s1) * 43'(INV_TWO_PI_Q32[14:0]);
		hi_s2   <= 43'(prod_s1) * 43'(INV_TWO_PI_Q32[29:15]);
		freq    <= (floor_val > 27'(FREQ_MAX)) ? FREQ_MAX : floor_val[23:0];
	end

endmodule

FILE: rtl/spmd_front.sv
module spmd_front import spmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] v_alpha,
	input  logic signed [15:0] v_beta,
	input  logic [14:0]        bus_voltage,
	input  logic [14:0]        max_mod_index,
	output logic               out_valid,
	output spmd_div_in_t       lane [3]
);

	localparam logic signed [33:0] K_SQRT = 34'(HALF_SQRT3_Q16);

	logic signed [33:0] a_half;
	logic signed [33:0] b_term;
	logic [29:0]        lim_raw;

	logic [3:0]         vld_s;
	logic signed [33:0] p_s1 [3];
	logic [30:0]        lim_s1;
	logic [14:0]        bus_s1;
	logic               low_s1;

	logic [31:0]        mag_s2 [3];
	logic [2:0]         neg_s2;
	logic [31:0]        mx_s2;
	logic [30:0]        lim_s2;
	logic [14:0]        bus_s2;
	logic               low_s2;

	logic [47:0]        num_s3 [3];
	logic [31:0]        den_s3;
	logic [2:0]         neg_s3;
	logic               low_s3;

	logic [31:0]        mag [3];
	logic [31:0]        mx;
	logic               scale;
	logic [REM_W-1:0]   x_val [3];

	always_comb begin
		a_half  = -({{3{v_alpha[15]}}, v_alpha, 15'b0});
		b_term  = 34'(v_beta) * K_SQRT;
		lim_raw = 30'(bus_voltage) * 30'(max_mod_index);
		for (int i = 0; i < 3; i++) begin
			mag[i] = p_s1[i][33] ? 32'(-p_s1[i]) : p_s1[i][31:0];
		end
		mx = mag[0];
		if (mag[1] > mx) begin
			mx = mag[1];
		end
		if (mag[2] > mx) begin
			mx = mag[2];
		end
		scale = mx_s2 > {1'b0, lim_s2};
		for (int i = 0; i < 3; i++) begin
			x_val[i] = (REM_W'(num_s3[i]) << 1) + REM_W'(den_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= {{2{v_alpha[15]}}, v_alpha, 16'b0};
		p_s1[1] <= a_half + b_term;
		p_s1[2] <= a_half - b_term;
		lim_s1  <= {lim_raw, 1'b0};
		bus_s1  <= bus_voltage;
		low_s1  <= bus_voltage <= BUS_MIN;

		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= mag[i];
			neg_s2[i] <= p_s1[i][33];
		end
		mx_s2  <= mx;
		lim_s2 <= lim_s1;
		bus_s2 <= bus_s1;
		low_s2 <= low_s1;

		for (int i = 0; i < 3; i++) begin
			num_s3[i] <= scale ? 48'(mag_s2[i]) * 48'({max_mod_index, 1'b0})
				: 48'(mag_s2[i]);
		end
		den_s3 <= scale ? mx_s2 : 32'(bus_s2);
		neg_s3 <= neg_s2;
		low_s3 <= low_s2;

		for (int i = 0; i < 3; i++) begin
			lane[i].x       <= x_val[i];
			lane[i].y       <= {den_s3, 1'b0};
			lane[i].ovf     <= x_val[i] >= (REM_W'({den_s3, 1'b0}) << QUO_W);
			lane[i].neg     <= neg_s3[i];
			lane[i].low_bus <= low_s3;
		end
	end

	assign out_valid = vld_s[3];

endmodule

FILE: rtl/spmd_div.sv
module spmd_div import spmd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  spmd_div_in_t in_data,
	output logic         out_valid,
	output logic [15:0]  duty
);

	logic [DIV_STEPS:0] vld_s;
	spmd_div_step_t     st_s [DIV_STEPS+1];
	logic [QUO_W-1:0]   m;
	logic [15:0]        duty_next;

	always_comb begin
		st_s[0].rem     = in_data.x;
		st_s[0].y       = in_data.y;
		st_s[0].q       = '0;
		st_s[0].ovf     = in_data.ovf;
		st_s[0].neg     = in_data.neg;
		st_s[0].low_bus = in_data.low_bus;
	end
	assign vld_s[0] = in_valid;

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		localparam int K = DIV_STEPS - 1 - i;
		logic [REM_W-1:0] sub;
		logic             fits;
		spmd_div_step_t   nxt;

		assign sub  = REM_W'(st_s[i].y) << K;
		assign fits = st_s[i].rem >= sub;

		always_comb begin
			nxt      = st_s[i];
			nxt.rem  = fits ? st_s[i].rem - sub : st_s[i].rem;
			nxt.q[K] = fits;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			st_s[i+1] <= nxt;
		end
	end

	always_comb begin
		if (st_s[DIV_STEPS].ovf || st_s[DIV_STEPS].q > QUO_CLAMP) begin
			m = QUO_CLAMP;
		end else begin
			m = st_s[DIV_STEPS].q;
		end
		if (st_s[DIV_STEPS].low_bus) begin
			duty_next = DUTY_HALF;
		end else if (st_s[DIV_STEPS].neg) begin
			duty_next = (m > QUO_W'(DUTY_HALF)) ? 16'd0 : 16'(QUO_W'(DUTY_HALF) - m);
		end else begin
			duty_next = (QUO_W'(DUTY_HALF) + m > QUO_W'(DUTY_MAX)) ? DUTY_MAX
				: 16'(QUO_W'(DUTY_HALF) + m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		duty <= duty_next;
	end

endmodule

FILE: rtl/synchronous_pulse_duty_modulator.sv
// Synchronous pulse duty modulator. A transaction is taken on every clock edge at which
// start is high; busy never rises, so one transaction may follow another in every cycle.
// Each transaction yields exactly one result, shown on switch_freq and the three duty
// ports for a single cycle while done is high. The pipeline runs through four stages of
// inverse Clarke transform, limit check and operand setup, then each phase's restoring
// divider, which settles one quotient bit per pipeline stage over 17 stages, and then one
// output stage. The receiver cannot hold results off, so results must be captured when
// done is high. Configuration writes take effect at once and must be made only while no
// transaction is still in flight.
module synchronous_pulse_duty_modulator import spmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [19:0] speed,
	input  logic signed [15:0] v_alpha,
	input  logic signed [15:0] v_beta,
	input  logic [14:0]        bus_voltage,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [19:0]        wr_data,
	output logic               done,
	output logic [23:0]        switch_freq,
	output logic [15:0]        duty_u,
	output logic [15:0]        duty_v,
	output logic [15:0]        duty_w
);

	logic [7:0]   pulse_ratio_q;
	logic [19:0]  min_carrier_q;
	logic [14:0]  max_mod_index_q;

	logic         front_valid;
	spmd_div_in_t lane [3];
	logic [23:0]  freq_early;
	logic [23:0]  freq_dly_s [FREQ_DLY];

	// The pipeline never stalls, so the block is always ready.
	assign busy = 1'b0;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ratio_q   <= PULSE_RATIO_RST;
			min_carrier_q   <= MIN_CARRIER_RST;
			max_mod_index_q <= MAX_MOD_INDEX_RST;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_PULSE_RATIO:   pulse_ratio_q   <= wr_data[7:0];
				CFG_MIN_CARRIER:   min_carrier_q   <= wr_data;
				CFG_MAX_MOD_INDEX: max_mod_index_q <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	// Carrier frequency path: shorter than the duty path, so it is delayed to match.
	spmd_freq u_freq (
		.clk         (clk),
		.speed       (speed),
		.pulse_ratio (pulse_ratio_q),
		.min_carrier (min_carrier_q),
		.freq        (freq_early)
	);

	always_ff @(posedge clk) begin
		freq_dly_s[0] <= freq_early;
		for (int i = 1; i < FREQ_DLY; i++) begin
			freq_dly_s[i] <= freq_dly_s[i-1];
		end
	end

	assign switch_freq = freq_dly_s[FREQ_DLY-1];

	// Phase voltages, overmodulation scaling and divider operands.
	spmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.v_alpha       (v_alpha),
		.v_beta        (v_beta),
		.bus_voltage   (bus_voltage),
		.max_mod_index (max_mod_index_q),
		.out_valid     (front_valid),
		.lane          (lane)
	);

	// One divider lane per phase; all three run in lockstep, so phase U marks the result.
	spmd_div u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_data   (lane[0]),
		.out_valid (done),
		.duty      (duty_u)
	);

	spmd_div u_div_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_data   (lane[1]),
		.out_valid (),
		.duty      (duty_v)
	);

	spmd_div u_div_w (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_data   (lane[2]),
		.out_valid (),
		.duty      (duty_w)
	);

endmodule

FILE: rtl/spmd_checker.sv
module spmd_checker import spmd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [14:0] bus_voltage,
	input logic        done,
	input logic [15:0] duty_u,
	input logic [15:0] duty_v,
	input logic [15:0] duty_w
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_LAT done)
		else $error("transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PIPE_LAT !done)
		else $error("result without transaction");

	a_low_bus_half: assert property (@(posedge clk) disable iff (!arst_n)
		(start && bus_voltage <= BUS_MIN) |-> ##PIPE_LAT
		(duty_u == DUTY_HALF && duty_v == DUTY_HALF && duty_w == DUTY_HALF))
		else $error("low bus duty not at half");

endmodule

bind synchronous_pulse_duty_modulator spmd_checker u_spmd_checker (.*);
